// File: sv/pixel_unshuffle_address_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel unshuffle address generator
// Clocked on clk; the reset-qualified form is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_UNSHUFFLE_ADDRESS_GENERATOR_CORE_DEFINES_SVH
`define PIXEL_UNSHUFFLE_ADDRESS_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// check a property at every clock edge outside reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check a property at every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: sv/puag_pkg.sv
// ----------------------------------------------------------------------------
// puag_pkg
// Shared types and constants of the pixel unshuffle address generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package puag_pkg;

    // port and field widths
    localparam int ELEM_W      = 32;
    localparam int PIXEL_W     = 32;
    localparam int DCHAN_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // counter and size widths
    localparam int IMG_W       = 16;
    localparam int CHAN_CNT_W  = 10;
    localparam int NCHAN_W     = 11;
    localparam int DIM_CNT_W   = 12;
    localparam int DIM_W       = 13;
    localparam int AREA_W      = 26;

    // room for the largest supported factor in transported fields
    localparam int PHASE_MAX_W  = 4;
    localparam int FACTOR_MAX_W = 5;

    // size limits
    localparam logic [NCHAN_W-1:0] MAX_CHANNELS = 11'd1024;
    localparam logic [DIM_W-1:0]   MAX_DIM      = 13'd4096;

    // depth of each word queue
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BATCHES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_SEL  = 3'd5;

    // channel order codes
    localparam logic ORDER_CHANNEL_MAJOR = 1'b0;
    localparam logic ORDER_SPATIAL_MAJOR = 1'b1;

    typedef struct packed {
        logic [IMG_W-1:0]   batches;
        logic [NCHAN_W-1:0] channels;
        logic [3:0]         factor;
        logic [DIM_W-1:0]   out_height;
        logic [DIM_W-1:0]   out_width;
        logic               order_sel;
    } cfg_t;

    // classified word: channel = (x * r + y) * m + z
    typedef struct packed {
        logic [ELEM_W-1:0]       element;
        logic [PIXEL_W-1:0]      pixel;
        logic [CHAN_CNT_W-1:0]   x;
        logic [PHASE_MAX_W-1:0]  y;
        logic [FACTOR_MAX_W-1:0] r;
        logic [NCHAN_W-1:0]      m;
        logic [CHAN_CNT_W-1:0]   z;
        logic                    last;
    } mid_item_t;

    typedef struct packed {
        logic [ELEM_W-1:0]     element;
        logic [PIXEL_W-1:0]    pixel;
        logic [DCHAN_W-1:0]    p1;
        logic [NCHAN_W-1:0]    m;
        logic [CHAN_CNT_W-1:0] z;
        logic                  last;
    } stage_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  element;
        logic [PIXEL_W-1:0] pixel;
        logic [DCHAN_W-1:0] channel;
        logic               last;
    } out_item_t;

endpackage

// File: sv/puag_fifo.sv
// ----------------------------------------------------------------------------
// puag_fifo
// Small flip-flop word queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pixel_unshuffle_address_generator_core_defines.svh"

module puag_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_RST(a_count_bound, count_reg <= FULL_CNT, "queue count beyond depth")
    `ASSERT_RST(a_push_grows, do_push && !do_pop |=> count_reg == $past(count_reg) + CNT_W'(1), "push without pop did not grow the queue")
    `ASSERT_RST(a_pop_shrinks, do_pop && !do_push |=> count_reg == $past(count_reg) - CNT_W'(1), "pop without push did not shrink the queue")

endmodule

// File: sv/puag_front.sv
// ----------------------------------------------------------------------------
// puag_front
// Accepts elements, walks the n, c, ho, dy, wo, dx counters and classifies
// each element into a pixel index and channel operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pixel_unshuffle_address_generator_core_defines.svh"

module puag_front #(
    parameter int MAX_FACTOR = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  puag_pkg::cfg_t              cfg,
    input  logic                        push,
    input  logic [puag_pkg::ELEM_W-1:0] element,
    output logic                        full,
    input  logic                        mid_full,
    output logic                        mid_push,
    output puag_pkg::mid_item_t         mid_item
);

    import puag_pkg::*;

    localparam int PW = $clog2(MAX_FACTOR);
    localparam int RW = $clog2(MAX_FACTOR + 1);
    localparam logic [ELEM_W-1:0] ELEM_MASK = ELEM_W'((64'd1 << ELEM_WIDTH) - 64'd1);

    logic [IMG_W-1:0]      img_reg, img_next;
    logic [CHAN_CNT_W-1:0] chan_reg, chan_next;
    logic [DIM_CNT_W-1:0]  orow_reg, orow_next;
    logic [PW-1:0]         rph_reg, rph_next;
    logic [DIM_CNT_W-1:0]  ocol_reg, ocol_next;
    logic [PW-1:0]         cph_reg, cph_next;
    logic [PIXEL_W-1:0]    base_reg, base_next;

    logic [IMG_W-1:0]   nb;
    logic [NCHAN_W-1:0] nc;
    logic [RW-1:0]      r;
    logic [DIM_W-1:0]   ho_n, wo_n;
    logic [AREA_W-1:0]  area;
    logic [PIXEL_W-1:0] chan_step;
    logic               accept;
    logic               col_wrap, ocol_wrap, rph_wrap, orow_wrap, chan_wrap, img_wrap;
    logic               last;

    assign full     = mid_full;
    assign accept   = push && !mid_full;
    assign mid_push = accept;

    // clamp sizes: zero acts as one, oversized acts as the limit
    always_comb
    begin
        nb = (cfg.batches == '0) ? IMG_W'(1) : cfg.batches;

        if (cfg.channels == '0)
            nc = NCHAN_W'(1);
        else if (cfg.channels > MAX_CHANNELS)
            nc = MAX_CHANNELS;
        else
            nc = cfg.channels;

        if (cfg.factor == '0)
            r = RW'(1);
        else if (32'(cfg.factor) > MAX_FACTOR)
            r = RW'(MAX_FACTOR);
        else
            r = RW'(cfg.factor);

        if (cfg.out_height == '0)
            ho_n = DIM_W'(1);
        else if (cfg.out_height > MAX_DIM)
            ho_n = MAX_DIM;
        else
            ho_n = cfg.out_height;

        if (cfg.out_width == '0)
            wo_n = DIM_W'(1);
        else if (cfg.out_width > MAX_DIM)
            wo_n = MAX_DIM;
        else
            wo_n = cfg.out_width;
    end

    // step back to the first output row for the next channel: +Wo - Ho*Wo
    assign area      = AREA_W'(ho_n) * AREA_W'(wo_n);
    assign chan_step = PIXEL_W'(wo_n) - PIXEL_W'(area);

    // wrap tests, greater-or-equal so a shrunk limit wraps at once
    assign col_wrap  = (RW'(cph_reg) + RW'(1)) >= r;
    assign ocol_wrap = (DIM_W'(ocol_reg) + DIM_W'(1)) >= wo_n;
    assign rph_wrap  = (RW'(rph_reg) + RW'(1)) >= r;
    assign orow_wrap = (DIM_W'(orow_reg) + DIM_W'(1)) >= ho_n;
    assign chan_wrap = (NCHAN_W'(chan_reg) + NCHAN_W'(1)) >= nc;
    assign img_wrap  = ({1'b0, img_reg} + 17'd1) >= {1'b0, nb};
    assign last      = col_wrap && ocol_wrap && rph_wrap && orow_wrap && chan_wrap
                       && img_wrap;

    // advance the counter chain, innermost first
    always_comb
    begin
        img_next  = img_reg;
        chan_next = chan_reg;
        orow_next = orow_reg;
        rph_next  = rph_reg;
        ocol_next = ocol_reg;
        cph_next  = cph_reg;
        base_next = base_reg;
        if (accept)
        begin
            if (!col_wrap)
            begin
                cph_next = cph_reg + PW'(1);
            end
            else
            begin
                cph_next = '0;
                if (!ocol_wrap)
                begin
                    ocol_next = ocol_reg + DIM_CNT_W'(1);
                end
                else
                begin
                    ocol_next = '0;
                    if (!rph_wrap)
                    begin
                        rph_next = rph_reg + PW'(1);
                    end
                    else
                    begin
                        rph_next = '0;
                        if (!orow_wrap)
                        begin
                            orow_next = orow_reg + DIM_CNT_W'(1);
                            base_next = base_reg + PIXEL_W'(wo_n);
                        end
                        else
                        begin
                            orow_next = '0;
                            if (!chan_wrap)
                            begin
                                chan_next = chan_reg + CHAN_CNT_W'(1);
                                base_next = base_reg + chan_step;
                            end
                            else
                            begin
                                chan_next = '0;
                                if (!img_wrap)
                                begin
                                    img_next  = img_reg + IMG_W'(1);
                                    base_next = base_reg + PIXEL_W'(wo_n);
                                end
                                else
                                begin
                                    img_next  = '0;
                                    base_next = '0;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_reg  <= '0;
            chan_reg <= '0;
            orow_reg <= '0;
            rph_reg  <= '0;
            ocol_reg <= '0;
            cph_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            img_reg  <= img_next;
            chan_reg <= chan_next;
            orow_reg <= orow_next;
            rph_reg  <= rph_next;
            ocol_reg <= ocol_next;
            cph_reg  <= cph_next;
            base_reg <= base_next;
        end
    end

    // classify: pick channel operands for the selected order
    always_comb
    begin
        mid_item.element = element & ELEM_MASK;
        mid_item.pixel   = base_reg + PIXEL_W'(ocol_reg);
        mid_item.r       = FACTOR_MAX_W'(r);
        mid_item.last    = last;
        if (cfg.order_sel == ORDER_SPATIAL_MAJOR)
        begin
            // (dy * r + dx) * C + c
            mid_item.x = CHAN_CNT_W'(rph_reg);
            mid_item.y = PHASE_MAX_W'(cph_reg);
            mid_item.m = nc;
            mid_item.z = chan_reg;
        end
        else
        begin
            // (c * r + dy) * r + dx
            mid_item.x = chan_reg;
            mid_item.y = PHASE_MAX_W'(rph_reg);
            mid_item.m = NCHAN_W'(r);
            mid_item.z = CHAN_CNT_W'(cph_reg);
        end
    end

    `ASSERT_RST(a_end_clears, accept && last |=> (cph_reg == '0) && (img_reg == '0) && (base_reg == '0), "counters not cleared after tensor end")
    `ASSERT_RST(a_col_step, accept && !col_wrap |=> cph_reg == $past(cph_reg) + PW'(1), "column phase did not advance")
    `ASSERT_RST(a_hold_idle, !accept |=> $stable(cph_reg) && $stable(base_reg) && $stable(img_reg), "counters moved without an accepted word")

endmodule

// File: sv/puag_back.sv
// ----------------------------------------------------------------------------
// puag_back
// Two-step channel arithmetic on classified words: p1 = x * r + y, then
// channel = p1 * m + z, both modulo 2^16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module puag_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mid_empty,
    input  puag_pkg::mid_item_t mid_item,
    output logic                mid_pop,
    input  logic                out_full,
    output logic                out_push,
    output puag_pkg::out_item_t out_item
);

    import puag_pkg::*;

    stage_t stage_reg, stage_next;
    logic   stage_valid_reg, stage_valid_next;
    logic   stage_load;

    // load the stage when it is free or draining this cycle
    assign stage_load = !stage_valid_reg || !out_full;
    assign mid_pop    = stage_load && !mid_empty;
    assign out_push   = stage_valid_reg && !out_full;

    // first product and add
    always_comb
    begin
        stage_next.element = mid_item.element;
        stage_next.pixel   = mid_item.pixel;
        stage_next.p1      = (DCHAN_W'(mid_item.x) * DCHAN_W'(mid_item.r))
                             + DCHAN_W'(mid_item.y);
        stage_next.m       = mid_item.m;
        stage_next.z       = mid_item.z;
        stage_next.last    = mid_item.last;
        stage_valid_next   = stage_load ? !mid_empty : stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // hold the stage payload while stalled
    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            stage_reg <= stage_next;
        end
    end

    // second product and add
    always_comb
    begin
        out_item.element = stage_reg.element;
        out_item.pixel   = stage_reg.pixel;
        out_item.channel = (stage_reg.p1 * DCHAN_W'(stage_reg.m)) + DCHAN_W'(stage_reg.z);
        out_item.last    = stage_reg.last;
    end

endmodule

// File: sv/pixel_unshuffle_address_generator_core.sv
// ----------------------------------------------------------------------------
// pixel_unshuffle_address_generator_core
// Space-to-depth scatter address generator for NCHW element streams.
// ----------------------------------------------------------------------------
// Usage:
//   Write batches, channels, factor, out_height, out_width and the order
//   select through cfg_write/cfg_index/cfg_data while the block is idle. Then
//   push tensor elements in raster order (n, c, h, w); an element is taken
//   when push is high and full is low. Each element comes back on the result
//   side with its destination pixel, destination channel and a tensor_end
//   flag on the last element; pop takes the word shown while empty is low.
//   An accepted element passes the classified-word queue, the arithmetic stage
//   and the result queue; one element per cycle is sustained while the receiver
//   keeps up, set by the front counter chain, which advances once per accepted word.
//   Reset clears all coordinate counters, empties both word queues and loads
//   the register defaults (N=1, C=3, r=2, Ho=1, Wo=1, channel-major).
//   When the receiver stalls the output queue, the arithmetic stage and the
//   classified-word queue fill in turn (five words) before full rises; no
//   word is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_unshuffle_address_generator_core #(
    parameter int ELEM_WIDTH = 32,
    parameter int MAX_FACTOR = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [puag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [puag_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [puag_pkg::ELEM_W-1:0]     element,
    output logic                            empty,
    input  logic                            pop,
    output logic [puag_pkg::ELEM_W-1:0]     out_element,
    output logic [puag_pkg::PIXEL_W-1:0]    dest_pixel,
    output logic [puag_pkg::DCHAN_W-1:0]    dest_channel,
    output logic                            tensor_end
);

    import puag_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    mid_item_t front_item, back_item;
    out_item_t stage_item, head_item;
    logic      mid_push, mid_full, mid_pop, mid_empty;
    logic      out_push, out_full;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BATCHES:    cfg_next.batches    = cfg_data;
                REG_CHANNELS:   cfg_next.channels   = cfg_data[NCHAN_W-1:0];
                REG_FACTOR:     cfg_next.factor     = cfg_data[3:0];
                REG_OUT_HEIGHT: cfg_next.out_height = cfg_data[DIM_W-1:0];
                REG_OUT_WIDTH:  cfg_next.out_width  = cfg_data[DIM_W-1:0];
                REG_ORDER_SEL:  cfg_next.order_sel  = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batches    <= IMG_W'(1);
            cfg_reg.channels   <= NCHAN_W'(3);
            cfg_reg.factor     <= 4'd2;
            cfg_reg.out_height <= DIM_W'(1);
            cfg_reg.out_width  <= DIM_W'(1);
            cfg_reg.order_sel  <= ORDER_CHANNEL_MAJOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: counters and classification
    puag_front #(
        .MAX_FACTOR (MAX_FACTOR),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .element  (element),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (front_item)
    );

    // queue between front and back
    puag_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (back_item),
        .empty (mid_empty)
    );

    // back: channel arithmetic
    puag_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (back_item),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (stage_item)
    );

    // result queue toward the receiver
    puag_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (stage_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (head_item),
        .empty (empty)
    );

    assign out_element  = head_item.element;
    assign dest_pixel   = head_item.pixel;
    assign dest_channel = head_item.channel;
    assign tensor_end   = head_item.last;

endmodule
